@@ sv/gaussian_5x5_downsample_by4_core_defines.svh @@
// Assertion macros for the gaussian 5x5 downsample-by-4 core.
// Included by the top level; define NO_ASSERTIONS to compile them out.
`ifndef GAUSSIAN_5X5_DOWNSAMPLE_BY4_CORE_DEFINES_SVH
`define GAUSSIAN_5X5_DOWNSAMPLE_BY4_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset.
`define G5D4_ASSERT_IMPL(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("g5d4: same-cycle check failed");
// Next-cycle implication, disabled during reset.
`define G5D4_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("g5d4: next-cycle check failed");
`else
`define G5D4_ASSERT_IMPL(label, clk, rst_n, pre, post)
`define G5D4_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif

`endif

@@ sv/g5d4_pkg.sv @@
// Shared types, constants and kernel table of the gaussian 5x5 downsample core.
// No dependencies.
`default_nettype none

package g5d4_pkg;

  localparam int unsigned PIX_IN_W      = 16;
  localparam int unsigned PIX_OUT_W     = 16;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned CFG_DATA_W    = 16;
  localparam int unsigned WIDTH_REG_W   = 13;
  localparam int unsigned HEIGHT_REG_W  = 16;
  localparam int unsigned WIN           = 5;
  localparam int unsigned LINES         = 4;

  localparam int unsigned DEF_MAX_WIDTH  = 4096;
  localparam int unsigned DEF_PIXEL_BITS = 16;
  localparam int unsigned DEF_Q_DEPTH    = 4;

  localparam logic [WIDTH_REG_W-1:0]  RESET_WIDTH  = 13'd4096;
  localparam logic [HEIGHT_REG_W-1:0] RESET_HEIGHT = 16'd4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [WIDTH_REG_W-1:0]  width;
    logic [HEIGHT_REG_W-1:0] height;
  } cfg_t;

  typedef struct packed {
    logic line_end;
    logic frame_end;
  } marks_t;

  // 5x5 kernel, weights sum to 159
  localparam logic [3:0] KERN [WIN][WIN] = '{
    '{4'd2, 4'd4,  4'd5,  4'd4,  4'd2},
    '{4'd4, 4'd9,  4'd12, 4'd9,  4'd4},
    '{4'd5, 4'd12, 4'd15, 4'd12, 4'd5},
    '{4'd4, 4'd9,  4'd12, 4'd9,  4'd4},
    '{4'd2, 4'd4,  4'd5,  4'd4,  4'd2}
  };

endpackage

`default_nettype wire

@@ sv/gaussian_5x5_downsample_by4_core.sv @@
// Top level of the 5x5 Gaussian filter with decimation by four.
// Depends on g5d4_pkg, g5d4_front, g5d4_queue, g5d4_back and the defines header.
//
// Usage:
//   Input channel: one 16-bit pixel per beat (pixel_in_i), raster order, one
//   image plane per frame. A beat moves when in_valid_i is high and in_stall_o
//   is low. Output channel: one filtered pixel per beat with line and frame
//   end marks; it moves when out_valid_o is high and out_stall_i is low.
//   Output (x,y) is the kernel sum centered on input (4x,4y), shifted right
//   by 8, and comes from the input beat at (4x+2,4y+2).
//   Configuration: write image_width (index 0) and image_height (index 1)
//   through cfg_valid_i/cfg_ready_o while the block is idle; ready is always
//   high.
//   Throughput: one input pixel per cycle while in_stall_o is low, set by the
//   two-port line store (one read and one write per column per cycle).
//   Path: after its input beat is accepted, a result reaches the output
//   through the line store read, the queue and two adder stages.
//   Stall: the output register holds its beat while out_stall_i is high; the
//   back end then fills, the 4-entry queue fills, and in_stall_o rises when
//   a pending result could not find a queue slot.
//   Reset: counters return to the start of a frame and the registers take
//   width 4096 and height 4096; the line store needs no clearing.
`default_nettype none
`include "gaussian_5x5_downsample_by4_core_defines.svh"

module gaussian_5x5_downsample_by4_core #(
  parameter int unsigned MAX_WIDTH   = g5d4_pkg::DEF_MAX_WIDTH,
  parameter int unsigned PIXEL_BITS  = g5d4_pkg::DEF_PIXEL_BITS,
  parameter int unsigned QUEUE_DEPTH = g5d4_pkg::DEF_Q_DEPTH
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration write channel
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [g5d4_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [g5d4_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // pixel input
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [g5d4_pkg::PIX_IN_W-1:0]     pixel_in_i,
  // pixel output
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [g5d4_pkg::PIX_OUT_W-1:0]         pixel_out_o,
  output logic                                   line_end_o,
  output logic                                   frame_end_o
);

  localparam int unsigned NW    = g5d4_pkg::WIN;
  localparam int unsigned WIN_W = NW * NW * PIXEL_BITS;
  localparam int unsigned QW    = WIN_W + $bits(g5d4_pkg::marks_t);
  localparam int unsigned LVL_W = $clog2(QUEUE_DEPTH + 1);

  g5d4_pkg::cfg_t cfg_q;

  logic                                  q_push;
  logic                                  q_pop;
  logic                                  q_valid;
  logic [LVL_W-1:0]                      q_level;
  logic [QW-1:0]                         q_head;
  logic [NW-1:0][NW-1:0][PIXEL_BITS-1:0] f_window;
  g5d4_pkg::marks_t                      f_marks;
  logic [NW-1:0][NW-1:0][PIXEL_BITS-1:0] b_window;
  g5d4_pkg::marks_t                      b_marks;
  g5d4_pkg::marks_t                      out_marks;

  // Take every configuration beat; the user must write only while idle, the block does not enforce it.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width  <= g5d4_pkg::RESET_WIDTH;
      cfg_q.height <= g5d4_pkg::RESET_HEIGHT;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        g5d4_pkg::CFG_IMAGE_WIDTH: begin
          cfg_q.width <= cfg_data_i[g5d4_pkg::WIDTH_REG_W-1:0];
        end
        g5d4_pkg::CFG_IMAGE_HEIGHT: begin
          cfg_q.height <= cfg_data_i[g5d4_pkg::HEIGHT_REG_W-1:0];
        end
        default: begin
          // drop writes to unused indexes
        end
      endcase
    end
  end

  // Front: count position, read and write the line store, build the window.
  g5d4_front #(
    .MAX_WIDTH   (MAX_WIDTH),
    .PIXEL_BITS  (PIXEL_BITS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .pixel_in_i (pixel_in_i),
    .q_level_i  (q_level),
    .push_o     (q_push),
    .window_o   (f_window),
    .marks_o    (f_marks)
  );

  // Queue: hold windows of output positions until the back end takes them.
  g5d4_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  ({f_marks, f_window}),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_head),
    .level_o (q_level)
  );

  assign b_marks  = q_head[QW-1:WIN_W];
  assign b_window = q_head[WIN_W-1:0];

  // Back: weighted sum over two stages; the second is the output register.
  g5d4_back #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_valid),
    .window_i     (b_window),
    .marks_i      (b_marks),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pixel_o      (pixel_out_o),
    .marks_o      (out_marks)
  );

  assign line_end_o  = out_marks.line_end;
  assign frame_end_o = out_marks.frame_end;

  `G5D4_ASSERT_IMPL(a_queue_no_overflow, clk_i, rst_ni, q_push,
                    (q_level != LVL_W'(QUEUE_DEPTH)) || q_pop)
  `G5D4_ASSERT_IMPL(a_queue_no_underflow, clk_i, rst_ni, q_pop, q_level != '0)
  `G5D4_ASSERT_NEXT(a_queue_level_grows, clk_i, rst_ni, q_push && !q_pop,
                    q_level == LVL_W'($past(q_level) + 1'b1))
  `G5D4_ASSERT_IMPL(a_frame_end_is_line_end, clk_i, rst_ni,
                    out_valid_o && frame_end_o, line_end_o)

endmodule

`default_nettype wire

@@ sv/g5d4_ram.sv @@
// Generic single-write, single-read RAM with registered read (read-first).
// No dependencies.
`default_nettype none

module g5d4_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ sv/g5d4_front.sv @@
// Front end: position counters, line store, column assembly and 5x5 window.
// Depends on g5d4_pkg and g5d4_ram.
`default_nettype none

module g5d4_front #(
  parameter int unsigned MAX_WIDTH   = g5d4_pkg::DEF_MAX_WIDTH,
  parameter int unsigned PIXEL_BITS  = g5d4_pkg::DEF_PIXEL_BITS,
  parameter int unsigned QUEUE_DEPTH = g5d4_pkg::DEF_Q_DEPTH,
  localparam int unsigned COL_W  = $clog2(MAX_WIDTH),
  localparam int unsigned WCNT_W = $clog2(MAX_WIDTH + 1),
  localparam int unsigned LVL_W  = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire g5d4_pkg::cfg_t                      cfg_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic [g5d4_pkg::PIX_IN_W-1:0]       pixel_in_i,
  input  wire logic [LVL_W-1:0]                    q_level_i,
  output logic                                     push_o,
  output logic [g5d4_pkg::WIN-1:0][g5d4_pkg::WIN-1:0][PIXEL_BITS-1:0] window_o,
  output g5d4_pkg::marks_t                         marks_o
);

  localparam int unsigned HW = g5d4_pkg::HEIGHT_REG_W;
  localparam int unsigned NW = g5d4_pkg::WIN;
  localparam int unsigned NL = g5d4_pkg::LINES;

  logic              accept;
  logic [WCNT_W-1:0] eff_w;
  logic [HW-1:0]     eff_h;
  logic [COL_W-1:0]  last_col;
  logic [HW-1:0]     last_row;
  logic [COL_W-1:0]  c;
  logic [HW-1:0]     r;
  logic [WCNT_W-1:0] c_ext;
  logic [WCNT_W-3:0] wq_m1;
  logic [HW-3:0]     hq_m1;
  logic              emit;
  g5d4_pkg::marks_t  marks;
  logic [1:0]        slot [NL];

  logic [COL_W-1:0]  col_q, col_d;
  logic [HW-1:0]     row_q, row_d;
  logic              s1_v_q;
  logic [PIXEL_BITS-1:0] s1_px_q;
  logic [1:0]        s1_slot_q [NL];
  logic              s1_first_row_q;
  logic              s1_first_col_q;
  logic              s1_emit_q;
  g5d4_pkg::marks_t  s1_marks_q;

  logic [PIXEL_BITS-1:0] line_rd [NL];
  logic [PIXEL_BITS-1:0] column  [NW];
  logic [NW-1:0][NW-1:0][PIXEL_BITS-1:0] window_q, window_d;

  // Hold back a new pixel while the queue could not take its result.
  assign in_stall_o = (32'(q_level_i) + 32'(s1_v_q & s1_emit_q)) >= QUEUE_DEPTH;
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    if (32'(cfg_i.width) > MAX_WIDTH) begin
      eff_w = WCNT_W'(MAX_WIDTH);
    end else if (cfg_i.width == '0) begin
      eff_w = WCNT_W'(1);
    end else begin
      eff_w = WCNT_W'(cfg_i.width);
    end
    eff_h = (cfg_i.height == '0) ? HW'(1) : cfg_i.height;
  end

  assign last_col = COL_W'(eff_w - 1'b1);
  assign last_row = eff_h - 1'b1;
  assign c        = (col_q > last_col) ? last_col : col_q;
  assign r        = (row_q > last_row) ? last_row : row_q;
  assign c_ext    = WCNT_W'(c);
  assign wq_m1    = eff_w[WCNT_W-1:2] - 1'b1;
  assign hq_m1    = eff_h[HW-1:2] - 1'b1;

  always_comb begin
    emit = (r[1:0] == 2'd2) && (c[1:0] == 2'd2) &&
           (c_ext[WCNT_W-1:2] < eff_w[WCNT_W-1:2]) && (r[HW-1:2] < eff_h[HW-1:2]);
    marks.line_end  = (c_ext[WCNT_W-1:2] == wq_m1);
    marks.frame_end = marks.line_end && (r[HW-1:2] == hq_m1);
    // line slot holding row r-4+k, rows above the top clamp to row 0
    for (int k = 0; k < NL; k++) begin
      if (32'(r) >= 32'(NL - k)) begin
        slot[k] = r[1:0] - 2'(NL - k);
      end else begin
        slot[k] = 2'd0;
      end
    end
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (c == last_col) begin
        col_d = '0;
        row_d = (r == last_row) ? '0 : r + 1'b1;
      end else begin
        col_d = c + 1'b1;
        row_d = r;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      s1_v_q <= 1'b0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      s1_v_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_px_q        <= pixel_in_i[PIXEL_BITS-1:0];
      s1_slot_q      <= slot;
      s1_first_row_q <= (r == '0);
      s1_first_col_q <= (c == '0);
      s1_emit_q      <= emit;
      s1_marks_q     <= marks;
    end
  end

  for (genvar s = 0; s < NL; s++) begin : g_line
    g5d4_ram #(
      .WIDTH (PIXEL_BITS),
      .DEPTH (MAX_WIDTH)
    ) u_line (
      .clk_i   (clk_i),
      .we_i    (accept && (r[1:0] == 2'(s))),
      .waddr_i (c),
      .wdata_i (pixel_in_i[PIXEL_BITS-1:0]),
      .re_i    (accept),
      .raddr_i (c),
      .rdata_o (line_rd[s])
    );
  end

  always_comb begin
    for (int k = 0; k < NL; k++) begin
      column[k] = s1_first_row_q ? s1_px_q : line_rd[s1_slot_q[k]];
    end
    column[NW-1] = s1_px_q;
    // replicate the first column of a line, else shift left by one
    for (int k = 0; k < NW; k++) begin
      for (int j = 0; j < NW; j++) begin
        if (s1_first_col_q || (j == NW - 1)) begin
          window_d[k][j] = column[k];
        end else begin
          window_d[k][j] = window_q[k][j+1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_v_q) begin
      window_q <= window_d;
    end
  end

  assign push_o   = s1_v_q & s1_emit_q;
  assign window_o = window_d;
  assign marks_o  = s1_marks_q;

endmodule

`default_nettype wire

@@ sv/g5d4_queue.sv @@
// Short FIFO between front and back end, flip-flop storage.
// No dependencies.
`default_nettype none

module g5d4_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned PTR_W = $clog2(DEPTH),
  localparam int unsigned LVL_W = $clog2(DEPTH + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output logic      [WIDTH-1:0] data_o,
  output logic      [LVL_W-1:0] level_o
);

  logic [WIDTH-1:0] slots_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [LVL_W-1:0] level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      level_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        level_q <= level_q + 1'b1;
      end else if (pop_i && !push_i) begin
        level_q <= level_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_q] <= data_i;
    end
  end

  assign valid_o = (level_q != '0);
  assign data_o  = slots_q[rd_q];
  assign level_o = level_q;

endmodule

`default_nettype wire

@@ sv/g5d4_back.sv @@
// Back end: two-stage weighted sum of the 5x5 window, ending in the output register.
// Depends on g5d4_pkg.
`default_nettype none

module g5d4_back #(
  parameter int unsigned PIXEL_BITS = g5d4_pkg::DEF_PIXEL_BITS
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                head_valid_i,
  input  wire logic [g5d4_pkg::WIN-1:0][g5d4_pkg::WIN-1:0][PIXEL_BITS-1:0] window_i,
  input  wire g5d4_pkg::marks_t                    marks_i,
  output logic                                     pop_o,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic [g5d4_pkg::PIX_OUT_W-1:0]           pixel_o,
  output g5d4_pkg::marks_t                         marks_o
);

  localparam int unsigned NW    = g5d4_pkg::WIN;
  localparam int unsigned SUM_W = PIXEL_BITS + 8;

  logic             en1, en2;
  logic [SUM_W-1:0] row_sum [NW];
  logic [SUM_W-1:0] total;

  logic                  v1_q, v2_q;
  logic [SUM_W-1:0]      row_sum_q [NW];
  g5d4_pkg::marks_t      marks1_q, marks2_q;
  logic [PIXEL_BITS-1:0] pixel_q;

  // Advance a stage when the one after it is empty or draining.
  assign en2   = !v2_q || !out_stall_i;
  assign en1   = !v1_q || en2;
  assign pop_o = head_valid_i && en1;

  always_comb begin
    for (int k = 0; k < NW; k++) begin
      row_sum[k] = '0;
      for (int j = 0; j < NW; j++) begin
        row_sum[k] = row_sum[k] +
                     SUM_W'(window_i[k][j]) * SUM_W'(g5d4_pkg::KERN[k][j]);
      end
    end
  end

  always_comb begin
    total = '0;
    for (int k = 0; k < NW; k++) begin
      total = total + row_sum_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= head_valid_i;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      row_sum_q <= row_sum;
      marks1_q  <= marks_i;
    end
    if (en2 && v1_q) begin
      pixel_q  <= total[SUM_W-1:8];
      marks2_q <= marks1_q;
    end
  end

  assign out_valid_o = v2_q;
  assign pixel_o     = g5d4_pkg::PIX_OUT_W'(pixel_q);
  assign marks_o     = marks2_q;

endmodule

`default_nettype wire
